// ----- sv/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_OUT
  } state_e;

  // Padding control for the block being compressed.
  typedef struct packed {
    logic       pad;
    logic       first;
    logic       len_en;
    logic [5:0] pos;
  } blk_mode_t;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage

// ----- sv/sha_buf.sv -----
// ----------------------------------------------------------------------------
// sha_buf
// Block buffer: 16 x 32-bit memory with byte-lane writes and a registered
// read; padding and length bytes are overlaid on the read word.
// ----------------------------------------------------------------------------
module sha_buf (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [5:0]         wr_pos_i,
  input  logic [7:0]         wr_byte_i,
  input  logic [3:0]         rd_addr_i,
  input  sha_pkg::blk_mode_t mode_i,
  input  logic [63:0]        len_i,
  output logic [31:0]        word_o
);
  import sha_pkg::*;

  logic [31:0] mem [BlockWords];
  logic [31:0] rd_data_q;
  logic [3:0]  rd_idx_q;

  // Byte 0 of a word sits in the top lane.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_pos_i[5:2]][8*(3 - {30'd0, wr_pos_i[1:0]}) +: 8] <= wr_byte_i;
    end
    rd_data_q <= mem[rd_addr_i];
    rd_idx_q  <= rd_addr_i;
  end

  always_comb begin
    logic [5:0] b;
    logic [7:0] mb;
    logic [7:0] ob;
    word_o = '0;
    for (int k = 0; k < 4; k++) begin
      b  = {rd_idx_q, 2'(k)};
      mb = rd_data_q[31 - 8*k -: 8];
      if (!mode_i.pad) begin
        ob = mb;
      end else if (mode_i.len_en && b >= 6'(LenOffset)) begin
        ob = len_i[63 - 8*{29'd0, b[2:0]} -: 8];
      end else if (mode_i.first && b < mode_i.pos) begin
        ob = mb;
      end else if (mode_i.first && b == mode_i.pos) begin
        ob = PadByte;
      end else begin
        ob = 8'h00;
      end
      word_o[31 - 8*k -: 8] = ob;
    end
  end

endmodule

// ----- sv/sha_core.sv -----
// ----------------------------------------------------------------------------
// sha_core
// One compression: 64 rounds, one per cycle, with a 16-word schedule window.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sha_pkg::hash_t hash_i,
  input  logic [31:0]   word_i,
  output logic [3:0]    rd_addr_o,
  output logic          done_o,
  output sha_pkg::hash_t vars_o
);
  import sha_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  r_q;
  hash_t       v_q;
  logic [15:0][31:0] w_q;
  logic [31:0] w_cur, t1, t2, ch, maj;

  // Fetch one word ahead of the round that uses it.
  assign rd_addr_o = busy_q ? (r_q[3:0] + 4'd1) : 4'd0;
  assign done_o    = done_q;
  assign vars_o    = v_q;

  always_comb begin
    if (r_q < 6'(BlockWords)) begin
      w_cur = word_i;
    end else begin
      w_cur = w_q[0] + sml_s0(w_q[1]) + w_q[9] + sml_s1(w_q[14]);
    end
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + big_s1(v_q[4]) + ch + round_k(r_q) + w_cur;
    t2  = big_s0(v_q[0]) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        r_q    <= '0;
      end else if (busy_q) begin
        r_q <= r_q + 6'd1;
        if (r_q == 6'(Rounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= hash_i;
    end else if (busy_q) begin
      w_q  <= {w_cur, w_q[15:1]};
      v_q  <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
    end
  end

endmodule

// ----- sv/sha256_hash_engine_unit.sv -----
// Absorb: a byte is taken each time the unit is idle; a full block then runs
// start, 64 rounds and the hash update before the next byte is taken.
// Finish: one or two compressions, then eight output beats.
// Rate is set by the single round unit, one round per cycle.
// Reset (rst_ni low, asynchronous) loads the initial hash, zero count.
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// SHA-256 over a byte stream: block buffer, round unit and sequencer.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  hash_t       hash_q, vars;
  logic [5:0]  pos_q;
  logic [63:0] count_q, len_q;
  blk_mode_t   mode_q;
  logic        second_q;
  logic [2:0]  idx_q;
  logic [3:0]  rd_addr;
  logic [31:0] word;
  logic        done, in_acc, out_acc, wr_en;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign wr_en       = in_acc && (operation_i == OP_ABSORB);

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  sha_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_pos_i  (pos_q),
    .wr_byte_i (data_byte_i),
    .rd_addr_i (rd_addr),
    .mode_i    (mode_q),
    .len_i     (len_q),
    .word_o    (word)
  );

  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_START),
    .hash_i    (hash_q),
    .word_i    (word),
    .rd_addr_o (rd_addr),
    .done_o    (done),
    .vars_o    (vars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_FINISH || pos_q == 6'd63)) begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_RUN;
      ST_RUN: begin
        if (done) begin
          if (!mode_q.pad) begin
            state_d = ST_IDLE;
          end else if (second_q) begin
            state_d = ST_START;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= InitHash;
      pos_q    <= '0;
      count_q  <= '0;
      mode_q   <= '0;
      second_q <= 1'b0;
      idx_q    <= '0;
      len_q    <= '0;
    end else begin
      if (in_acc) begin
        if (operation_i == OP_ABSORB) begin
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd63) begin
            count_q <= count_q + 64'd512;
            mode_q  <= '0;
          end
        end else begin
          len_q       <= count_q + {55'd0, pos_q, 3'b000};
          mode_q.pad  <= 1'b1;
          mode_q.first <= 1'b1;
          mode_q.pos  <= pos_q;
          // Length does not fit after the pad byte: spill into a second block.
          mode_q.len_en <= (pos_q < 6'(LenOffset));
          second_q    <= (pos_q >= 6'(LenOffset));
        end
      end
      if (state_q == ST_RUN && done) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + vars[i];
        end
        if (mode_q.pad && second_q) begin
          second_q      <= 1'b0;
          mode_q.first  <= 1'b0;
          mode_q.len_en <= 1'b1;
        end
        idx_q <= '0;
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          hash_q  <= InitHash;
          pos_q   <= '0;
          count_q <= '0;
        end
      end
    end
  end

endmodule

// ----- verif/sha256_hash_engine_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_tb
// Drives byte beats and finish beats into the SHA-256 engine. A local SHA-256
// model predicts the eight digest words of every message, and each output beat
// is checked against the oldest predicted word. Both sides idle at random.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit_tb;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  // Local copy of the hash state.
  logic [31:0] mdl_hash [8];
  logic [7:0]  mdl_buf [64];
  int unsigned mdl_pos;
  logic [63:0] mdl_bits;

  digest_beat_t digest_q[$];
  int unsigned  n_errors;
  int unsigned  n_words;
  int unsigned  n_msgs;
  int unsigned  n_bytes;
  int unsigned  cycles;
  bit           calm;

  sha256_hash_engine_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_reset();
    mdl_hash = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    foreach (mdl_buf[i]) mdl_buf[i] = 8'h00;
    mdl_pos  = 0;
    mdl_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {mdl_buf[4*r], mdl_buf[4*r+1], mdl_buf[4*r+2], mdl_buf[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = w[r-16] + w[r-7]
           + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
           + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
    v = mdl_hash;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_hash[i] += v[i];
  endfunction

  // Advance the model by one accepted beat; a finish queues eight words.
  function automatic void hash_step(op_e op, logic [7:0] b);
    digest_beat_t d;
    if (op == OP_ABSORB) begin
      mdl_buf[mdl_pos] = b;
      mdl_pos++;
      if (mdl_pos == 64) begin
        compress_block();
        mdl_bits += 64'd512;
        mdl_pos = 0;
      end
      return;
    end
    mdl_bits += 64'(mdl_pos * 8);
    mdl_buf[mdl_pos] = PadByte;
    for (int i = mdl_pos + 1; i < 64; i++) mdl_buf[i] = 8'h00;
    if (mdl_pos >= LenOffset) begin
      compress_block();
      foreach (mdl_buf[i]) mdl_buf[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) mdl_buf[LenOffset + i] = mdl_bits[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      d.word = mdl_hash[i];
      d.idx  = 3'(i);
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    hash_reset();
  endfunction

  // Hold valid across back-to-back beats; drop it only for an idle stretch.
  task automatic send_beat(op_e op, logic [7:0] b);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid_i  <= 1'b0;
      operation_i <= 1'($urandom_range(1));
      data_byte_i <= 8'($urandom_range(255));
      do @(posedge clk_i); while ($urandom_range(99) < 12);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    hash_step(op, b);
    if (op == OP_FINISH) n_msgs++;
    else n_bytes++;
  endtask

  task automatic send_message(int unsigned len, int unsigned fill);
    for (int unsigned i = 0; i < len; i++)
      send_beat(OP_ABSORB, (fill > 255) ? 8'($urandom_range(255)) : 8'(fill));
    send_beat(OP_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digest_q.size() != 0);
  endtask

  // Empty message, one byte, and a length that spills padding into a second block.
  task automatic test_lengths();
    send_message(0, 256);
    send_message(1, 8'hff);
    send_message(56, 8'h00);
  endtask

  // Drain completely, then send a full block back-to-back with no idling.
  task automatic test_drained_restart();
    wait_drain();
    calm = 1'b1;
    send_message(64, 256);
    calm = 1'b0;
  endtask

  task automatic test_random_messages();
    int unsigned len;
    for (int m = 0; m < 2; m++) begin
      len = $urandom_range(0, 4);
      send_message(len, 256);
    end
  endtask

  // Output side: random stalls with a calm window, compare each beat.
  always @(posedge clk_i) begin
    digest_beat_t exp_b;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat word=%h idx=%0d", $time,
                   digest_word_o, word_index_o);
          n_errors++;
        end else begin
          exp_b = digest_q.pop_front();
          n_words++;
          if (digest_word_o !== exp_b.word || word_index_o !== exp_b.idx
              || last_word_o !== exp_b.last) begin
            $display("%0t: digest mismatch exp word=%h idx=%0d last=%0b",
                     $time, exp_b.word, exp_b.idx, exp_b.last);
            $display("%0t:                 got word=%h idx=%0d last=%0b",
                     $time, digest_word_o, word_index_o, last_word_o);
            n_errors++;
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("sha256_hash_engine_unit_tb failed");
      $finish;
    end
  end

  initial begin
    n_errors = 0; n_words = 0; n_msgs = 0; n_bytes = 0; cycles = 0; calm = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_ABSORB;
    data_byte_i = 8'h00;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    hash_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_lengths();
    test_drained_restart();
    test_random_messages();
    wait_drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d messages, %0d bytes, %0d digest words checked",
             n_msgs, n_bytes, n_words);
    $display("lengths include empty, a two-block pad spill and a full block");
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("sha256_hash_engine_unit_tb passed");
    end else begin
      $display("%0d errors, %0d words never seen", n_errors, digest_q.size());
      $display("sha256_hash_engine_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sha_pkg.sv
sv/sha_buf.sv
sv/sha_core.sv
sv/sha256_hash_engine_unit.sv
verif/sha256_hash_engine_unit_tb.sv
